[rtl/skti_pkg.sv]
`timescale 1ns / 1ps

package skti_pkg;

	// Default number of table slots.
	localparam int DEPTH_DEFAULT = 64;

	// Cells whose match results are merged in one registered group.
	localparam int GROUP_SIZE = 32;

	localparam int KEY_W     = 64;
	localparam int STATUS_W  = 8;
	localparam int LIMIT_W   = 7;
	localparam int ADDR_W    = 4;
	localparam int PDATA_W   = 64;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET      = 7'd64;
	localparam logic [KEY_W-1:0]    AUTO_KEY_RESET   = 64'd1;
	localparam logic [STATUS_W-1:0] STATUS_SCHEDULED = 8'd1;

	// Request kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_FIND   = 1'b1;

	// Register indexes, taken from the eight-byte address stride.
	localparam logic REG_TABLE_LIMIT    = 1'b0;
	localparam logic REG_FIRST_AUTO_KEY = 1'b1;

	typedef enum logic [1:0] {
		OUT_OK,
		OUT_FULL,
		OUT_DUP,
		OUT_NOT_FOUND
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CMP,
		ST_GRP,
		ST_SEL
	} state_t;

	typedef struct packed {
		logic                kind;
		logic [KEY_W-1:0]    entry_key;
		logic [STATUS_W-1:0] entry_status;
		logic [KEY_W-1:0]    entry_origin;
		logic [KEY_W-1:0]    entry_payload;
	} req_item_t;

	typedef struct packed {
		outcome_t            outcome;
		logic [KEY_W-1:0]    result_key;
		logic [STATUS_W-1:0] result_status;
		logic [KEY_W-1:0]    result_origin;
		logic [KEY_W-1:0]    result_payload;
	} rsp_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic latch;
		logic prep;
		logic compare;
		logic reduce;
		logic commit;
	} cmd_t;

	// Register block to datapath configuration.
	typedef struct packed {
		logic [LIMIT_W-1:0] table_limit;
		logic               nak_load;
		logic [KEY_W-1:0]   nak_value;
	} cfg_t;

endpackage

[rtl/sorted_key_table_insert_find.sv]
`timescale 1ns / 1ps
// Channel   Handshake                  Payload       Role
// req       req_valid / req_ready      req_item_t    insert or find request
// rsp       rsp_valid / rsp_ready      rsp_item_t    one result per request
// apb       psel penable pwrite pready paddr pwdata  table_limit, first_auto_key
//
// A request is accepted only while the controller is idle, so the block takes no new request
// before it has committed the result of the last one. The result is registered after the
// prep, compare, group merge and final merge steps that search the row of
// compare-and-shift cells before an insert can commit.
// A pending result does not block the next request; it stalls only the
// final step of the next item. Reset clears the entry count and sets the automatic key
// counter to one; the cells hold nothing valid and need no clearing pass.

module sorted_key_table_insert_find import skti_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_item_t          req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_item_t          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cmd_t cmd;
	cfg_t cfg;

	// Registers are eight bytes apart because first_auto_key is 64 bits wide.
	skti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller sequences each transaction and owns the result valid.
	skti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// The datapath holds the sorted cells, the counters and the result register.
	skti_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[rtl/skti_regs.sv]
`timescale 1ns / 1ps

module skti_regs import skti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [LIMIT_W-1:0] limit_q;
	logic [KEY_W-1:0]   first_key_q;
	logic               wr;
	logic               sel_idx;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign sel_idx = paddr[ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			first_key_q <= AUTO_KEY_RESET;
		end else if (wr) begin
			if (sel_idx == REG_TABLE_LIMIT) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end else begin
				first_key_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (sel_idx == REG_FIRST_AUTO_KEY) begin
			prdata = first_key_q;
		end else begin
			prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
		end
	end

	assign cfg.table_limit = limit_q;
	assign cfg.nak_load    = wr && (sel_idx == REG_FIRST_AUTO_KEY);
	assign cfg.nak_value   = pwdata;

endmodule

[rtl/skti_ctrl.sv]
`timescale 1ns / 1ps

module skti_ctrl import skti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_GRP;
			end
			ST_GRP: begin
				cmd.reduce = 1'b1;
				state_d    = ST_SEL;
			end
			ST_SEL: begin
				// Hold here while the previous result is still waiting.
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/skti_dp.sv]
`timescale 1ns / 1ps

module skti_dp import skti_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  cfg_t      cfg,
	input  req_item_t req,
	output rsp_item_t rsp
);

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CAPW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int NG   = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	req_item_t           item_q;
	logic [CW-1:0]       count_q;
	logic [KEY_W-1:0]    nak_q;
	logic                full_q;

	logic [KEY_W-1:0]    cell_key_q     [TABLE_DEPTH];
	logic [STATUS_W-1:0] cell_status_q  [TABLE_DEPTH];
	logic [KEY_W-1:0]    cell_origin_q  [TABLE_DEPTH];
	logic [KEY_W-1:0]    cell_payload_q [TABLE_DEPTH];

	logic [TABLE_DEPTH-1:0] lt_q;
	logic [TABLE_DEPTH-1:0] eq_q;

	logic [NG-1:0]       grp_hit_q;
	logic [STATUS_W-1:0] grp_status_q  [NG];
	logic [KEY_W-1:0]    grp_origin_q  [NG];
	logic [KEY_W-1:0]    grp_payload_q [NG];

	logic [NG-1:0]       grp_hit_d;
	logic [STATUS_W-1:0] grp_status_d  [NG];
	logic [KEY_W-1:0]    grp_origin_d  [NG];
	logic [KEY_W-1:0]    grp_payload_d [NG];

	logic [CAPW-1:0]     cap;
	logic                full;
	logic                draw;
	logic                hit;
	logic [STATUS_W-1:0] hit_status;
	logic [KEY_W-1:0]    hit_origin;
	logic [KEY_W-1:0]    hit_payload;
	logic                do_write;
	logic [STATUS_W-1:0] new_status;
	logic [KEY_W-1:0]    new_origin;
	rsp_item_t           rsp_d;
	rsp_item_t           rsp_q;

	// Usable capacity is the smaller of the limit register and the depth.
	always_comb begin
		if (CAPW'(cfg.table_limit) < CAPW'(TABLE_DEPTH)) begin
			cap = CAPW'(cfg.table_limit);
		end else begin
			cap = CAPW'(TABLE_DEPTH);
		end
	end

	assign full = CAPW'(count_q) >= cap;
	assign draw = cmd.prep && (item_q.kind == KIND_INSERT) && !full &&
		(item_q.entry_key == '0);

	// Request capture; the key is replaced by an automatic key when drawn.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req;
		end else if (draw) begin
			item_q.entry_key <= (nak_q == '0) ? KEY_W'(1) : nak_q;
		end
		if (cmd.prep) begin
			full_q <= full;
		end
	end

	// A drawn zero is skipped, so a wrapped counter yields one and moves to two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nak_q <= AUTO_KEY_RESET;
		end else if (cfg.nak_load) begin
			nak_q <= (cfg.nak_value == '0) ? KEY_W'(1) : cfg.nak_value;
		end else if (draw) begin
			nak_q <= (nak_q == '0) ? KEY_W'(2) : nak_q + KEY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_write) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Per-cell compare against the search key.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				lt_q[i] <= (count_q > CW'(i)) && (cell_key_q[i] < item_q.entry_key);
				eq_q[i] <= (count_q > CW'(i)) && (cell_key_q[i] == item_q.entry_key);
			end
		end
	end

	// First reduction level: merge the matching cell within each group.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_hit_d[g]     = 1'b0;
			grp_status_d[g]  = '0;
			grp_origin_d[g]  = '0;
			grp_payload_d[g] = '0;
			for (int c = 0; c < GROUP_SIZE; c++) begin
				if ((g * GROUP_SIZE + c) < TABLE_DEPTH) begin
					if (eq_q[g * GROUP_SIZE + c]) begin
						grp_hit_d[g]     = 1'b1;
						grp_status_d[g]  = grp_status_d[g] |
							cell_status_q[g * GROUP_SIZE + c];
						grp_origin_d[g]  = grp_origin_d[g] |
							cell_origin_q[g * GROUP_SIZE + c];
						grp_payload_d[g] = grp_payload_d[g] |
							cell_payload_q[g * GROUP_SIZE + c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reduce) begin
			grp_hit_q     <= grp_hit_d;
			grp_status_q  <= grp_status_d;
			grp_origin_q  <= grp_origin_d;
			grp_payload_q <= grp_payload_d;
		end
	end

	// Second reduction level across groups.
	always_comb begin
		hit         = |grp_hit_q;
		hit_status  = '0;
		hit_origin  = '0;
		hit_payload = '0;
		for (int g = 0; g < NG; g++) begin
			if (grp_hit_q[g]) begin
				hit_status  = hit_status | grp_status_q[g];
				hit_origin  = hit_origin | grp_origin_q[g];
				hit_payload = hit_payload | grp_payload_q[g];
			end
		end
	end

	assign do_write = cmd.commit && (item_q.kind == KIND_INSERT) && !full_q && !hit;

	assign new_status = (item_q.entry_status != '0) ? item_q.entry_status :
		STATUS_SCHEDULED;
	assign new_origin = (item_q.entry_origin != '0) ? item_q.entry_origin :
		item_q.entry_key;

	// Cells below the insertion point keep their entry, the insertion point
	// takes the new entry and every cell above takes its lower neighbor.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic take_new;
		if (i == 0) begin : g_first
			assign take_new = 1'b1;
		end else begin : g_rest
			assign take_new = lt_q[i-1];
		end
		always_ff @(posedge clk) begin
			if (do_write && !lt_q[i]) begin
				if (take_new) begin
					cell_key_q[i]     <= item_q.entry_key;
					cell_status_q[i]  <= new_status;
					cell_origin_q[i]  <= new_origin;
					cell_payload_q[i] <= item_q.entry_payload;
				end else if (i > 0) begin
					cell_key_q[i]     <= cell_key_q[(i > 0) ? i - 1 : 0];
					cell_status_q[i]  <= cell_status_q[(i > 0) ? i - 1 : 0];
					cell_origin_q[i]  <= cell_origin_q[(i > 0) ? i - 1 : 0];
					cell_payload_q[i] <= cell_payload_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	// Result fields that the outcome does not use stay zero.
	always_comb begin
		rsp_d = '0;
		if (item_q.kind == KIND_FIND) begin
			if (hit) begin
				rsp_d.outcome        = OUT_OK;
				rsp_d.result_key     = item_q.entry_key;
				rsp_d.result_status  = hit_status;
				rsp_d.result_origin  = hit_origin;
				rsp_d.result_payload = hit_payload;
			end else begin
				rsp_d.outcome = OUT_NOT_FOUND;
			end
		end else if (full_q) begin
			rsp_d.outcome = OUT_FULL;
		end else if (hit) begin
			rsp_d.outcome    = OUT_DUP;
			rsp_d.result_key = item_q.entry_key;
		end else begin
			rsp_d.outcome    = OUT_OK;
			rsp_d.result_key = item_q.entry_key;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/skti_checker.sv]
`timescale 1ns / 1ps

module skti_checker import skti_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input rsp_item_t          rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in work");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome == OUT_FULL) |->
		(rsp.result_key == '0) && (rsp.result_status == '0) &&
		(rsp.result_origin == '0) && (rsp.result_payload == '0))
		else $error("table full result carries data");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome == OUT_NOT_FOUND) |->
		(rsp.result_key == '0) && (rsp.result_status == '0) &&
		(rsp.result_origin == '0) && (rsp.result_payload == '0))
		else $error("not found result carries data");

endmodule

bind sorted_key_table_insert_find skti_checker u_skti_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import skti_pkg::*;

	// The block is built with its default depth, so the table model uses the same size.
	localparam int SLOTS = DEPTH_DEFAULT;

	// Register addresses. Because the first automatic key is 64 bits wide, the registers sit
	// on an eight-byte stride.
	localparam logic [ADDR_W-1:0] ADDR_TABLE_LIMIT    = {REG_TABLE_LIMIT, 3'b000};
	localparam logic [ADDR_W-1:0] ADDR_FIRST_AUTO_KEY = {REG_FIRST_AUTO_KEY, 3'b000};

	// The run fails when no transaction has happened on any port for this many cycles.
	localparam int QUIET_LIMIT = 1000;

	// The longest gap the sender inserts in front of one request.
	localparam int MAX_GAP = 20;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_item_t          req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_item_t          rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [ADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	sorted_key_table_insert_find dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	// Model of the table. Only the first table_count slots hold entries, and they are kept in
	// ascending key order, exactly as the block is meant to keep its cells.
	logic [KEY_W-1:0]    table_keys     [SLOTS];
	logic [STATUS_W-1:0] table_status   [SLOTS];
	logic [KEY_W-1:0]    table_origins  [SLOTS];
	logic [KEY_W-1:0]    table_payloads [SLOTS];
	int                  table_count    = 0;
	logic [LIMIT_W-1:0]  limit_setting  = LIMIT_RESET;
	logic [KEY_W-1:0]    auto_key_next  = AUTO_KEY_RESET;

	// Results the block still owes, oldest first.
	rsp_item_t pending_results [$];

	// Traffic shaping for the current phase, in percent per cycle.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	int failures      = 0;
	int results_seen  = 0;
	int inserts_sent  = 0;
	int finds_sent    = 0;
	int outcome_tally [4];

	// Returns the slot that holds the key or where it belongs; hit tells which.
	function automatic int find_slot(input logic [KEY_W-1:0] key, output bit hit);
		int slot;
		hit = 1'b0;
		for (slot = 0; slot < table_count; slot++) begin
			if (table_keys[slot] == key) begin
				hit = 1'b1;
				return slot;
			end
			if (table_keys[slot] > key)
				return slot;
		end
		return slot;
	endfunction

	// Applies one request to the table model and returns the result the block must give.
	function automatic rsp_item_t apply_request(input req_item_t item);
		rsp_item_t        res;
		logic [KEY_W-1:0] key;
		int               capacity;
		int               slot;
		bit               hit;
		res = '0;
		key = item.entry_key;
		if (item.kind == KIND_FIND) begin
			slot = find_slot(key, hit);
			if (!hit) begin
				res.outcome = OUT_NOT_FOUND;
			end else begin
				res.outcome        = OUT_OK;
				res.result_key     = table_keys[slot];
				res.result_status  = table_status[slot];
				res.result_origin  = table_origins[slot];
				res.result_payload = table_payloads[slot];
			end
			return res;
		end
		// A full table is reported before any automatic key is drawn.
		capacity = (int'(limit_setting) < SLOTS) ? int'(limit_setting) : SLOTS;
		if (table_count >= capacity) begin
			res.outcome = OUT_FULL;
			return res;
		end
		// A zero request key draws the next automatic key. Zero itself is never handed out,
		// so a wrapped counter draws once more.
		if (key == '0) begin
			key = auto_key_next;
			auto_key_next++;
			if (key == '0) begin
				key = auto_key_next;
				auto_key_next++;
			end
		end
		res.result_key = key;
		slot = find_slot(key, hit);
		if (hit) begin
			res.outcome = OUT_DUP;
			return res;
		end
		for (int i = table_count; i > slot; i--) begin
			table_keys[i]     = table_keys[i-1];
			table_status[i]   = table_status[i-1];
			table_origins[i]  = table_origins[i-1];
			table_payloads[i] = table_payloads[i-1];
		end
		table_keys[slot]     = key;
		table_status[slot]   = (item.entry_status == '0) ? STATUS_SCHEDULED : item.entry_status;
		table_origins[slot]  = (item.entry_origin == '0) ? key : item.entry_origin;
		table_payloads[slot] = item.entry_payload;
		table_count++;
		res.outcome = OUT_OK;
		return res;
	endfunction

	task automatic report_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("%s", what);
	endtask

	// Sends one request. The sender may first go idle for a random number of cycles. Once
	// valid is raised it stays up with the same payload until the request is taken, and the
	// expected result is worked out at that same edge.
	task automatic send_request(input req_item_t item);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(apply_request(item));
		if (item.kind == KIND_INSERT)
			inserts_sent++;
		else
			finds_sent++;
	endtask

	task automatic send_fields(input logic kind, input logic [KEY_W-1:0] key,
			input logic [STATUS_W-1:0] status, input logic [KEY_W-1:0] origin,
			input logic [KEY_W-1:0] payload);
		req_item_t item;
		item.kind          = kind;
		item.entry_key     = key;
		item.entry_status  = status;
		item.entry_origin  = origin;
		item.entry_payload = payload;
		send_request(item);
	endtask

	// Drops valid and holds off until every result still owed has been taken.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One APB write: setup cycle, access cycle, then back to the idle state. The model is
	// updated at the edge where the block takes the write.
	task automatic write_register(input logic [ADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_TABLE_LIMIT)
			limit_setting = data[LIMIT_W-1:0];
		else
			auto_key_next = (data == '0) ? AUTO_KEY_RESET : data;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only written while the block has nothing in flight.
	task automatic set_table_limit(input logic [LIMIT_W-1:0] value);
		wait_for_results();
		write_register(ADDR_TABLE_LIMIT, PDATA_W'(value));
	endtask

	task automatic set_first_auto_key(input logic [KEY_W-1:0] value);
		wait_for_results();
		write_register(ADDR_FIRST_AUTO_KEY, value);
	endtask

	function automatic logic [KEY_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Keys favor entries already in the table and their neighbors, so that finds hit,
	// inserts collide and new keys land between existing ones.
	function automatic logic [KEY_W-1:0] random_key();
		int pick;
		int slot;
		pick = $urandom_range(9);
		slot = (table_count > 0) ? $urandom_range(table_count - 1) : 0;
		if (table_count > 0 && pick < 3)
			return table_keys[slot];
		if (table_count > 0 && pick == 3)
			return $urandom_range(1) ? table_keys[slot] + 1'b1 : table_keys[slot] - 1'b1;
		if (pick == 4)
			return '0;
		if (pick == 5)
			return '1;
		if (pick < 8)
			return KEY_W'($urandom_range(1, 300));
		return random_word();
	endfunction

	function automatic req_item_t random_request(input int insert_pct);
		req_item_t item;
		item.kind          = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_FIND;
		item.entry_key     = random_key();
		item.entry_status  = ($urandom_range(4) == 0) ? '0 : STATUS_W'($urandom_range(255));
		item.entry_origin  = ($urandom_range(3) == 0) ? '0 : random_word();
		item.entry_payload = random_word();
		return item;
	endfunction

	// Result checker: every result the block hands over is compared with the oldest one owed.
	always @(posedge clk) begin : check_results
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			outcome_tally[rsp.outcome]++;
			if (pending_results.size() == 0) begin
				report_failure($sformatf("unexpected result: outcome %0d key %h",
					rsp.outcome, rsp.result_key));
			end else begin
				want = pending_results.pop_front();
				if (rsp.outcome !== want.outcome || rsp.result_key !== want.result_key
						|| rsp.result_status !== want.result_status
						|| rsp.result_origin !== want.result_origin
						|| rsp.result_payload !== want.result_payload)
					report_failure($sformatf({"result %0d mismatch:\n",
						"  expected outcome %0d key %h status %h origin %h payload %h\n",
						"  actual   outcome %0d key %h status %h origin %h payload %h"},
						results_seen, want.outcome, want.result_key, want.result_status,
						want.result_origin, want.result_payload, rsp.outcome, rsp.result_key,
						rsp.result_status, rsp.result_origin, rsp.result_payload));
			end
		end
	end

	// The receiver stalls at random, at the rate that the current phase asks for.
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= stall_pct);

	// Watchdog: a hung handshake on any port ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// Basic inserts and finds at reset settings: extreme keys, default status and origin,
	// an automatic key that collides, an explicit duplicate and a key that lands in the middle.
	task automatic test_insert_and_find();
		send_fields(KIND_FIND,   64'd5, '0, '0, '0);
		send_fields(KIND_INSERT, '1, '0, '0, '0);
		send_fields(KIND_INSERT, 64'd1, '1, '1, '1);
		send_fields(KIND_INSERT, '0, 8'h42, 64'h1234, 64'hAAAA_AAAA_AAAA_AAAA);
		send_fields(KIND_INSERT, '0, 8'h00, 64'h0, 64'h5555_5555_5555_5555);
		send_fields(KIND_INSERT, 64'd2, 8'h07, 64'h9, 64'h0);
		send_fields(KIND_INSERT, 64'h8000_0000_0000_0000, 8'h80, '0, 64'hDEAD_BEEF);
		send_fields(KIND_FIND,   '1, '0, '0, '0);
		send_fields(KIND_FIND,   64'd1, '0, '0, '0);
		send_fields(KIND_FIND,   64'h8000_0000_0000_0000, '1, '1, '1);
		send_fields(KIND_FIND,   '0, '0, '0, '0);
		send_fields(KIND_FIND,   64'd3, '0, '0, '0);
	endtask

	// The automatic key counter runs past the top, skips zero, and then collides with keys
	// already stored. Writing zero restarts the counter at one.
	task automatic test_auto_key_wrap();
		set_first_auto_key(64'hFFFF_FFFF_FFFF_FFFE);
		repeat (5)
			send_fields(KIND_INSERT, '0, '0, '0, random_word());
		send_fields(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0);
		set_first_auto_key('0);
		send_fields(KIND_INSERT, '0, 8'h11, '0, '0);
	endtask

	// A limit at, below and far under the entry count must report a full table without using
	// up an automatic key, while stored entries stay visible. A limit above the depth acts as
	// the depth.
	task automatic test_table_limit();
		set_table_limit(LIMIT_W'(table_count));
		send_fields(KIND_INSERT, '0, '0, '0, '0);
		send_fields(KIND_INSERT, 64'd10, '0, '0, '0);
		set_table_limit(7'd2);
		send_fields(KIND_FIND,   64'd3, '0, '0, '0);
		send_fields(KIND_INSERT, 64'd11, '0, '0, '0);
		set_table_limit(7'd0);
		send_fields(KIND_INSERT, '0, '0, '0, '0);
		set_table_limit(7'd127);
		repeat (3)
			send_fields(KIND_INSERT, '0, '0, '0, random_word());
	endtask

	task automatic run_traffic(input int count, input int idle_pct, input int stall,
			input int insert_pct);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		repeat (count) begin
			send_request(random_request(insert_pct));
			if ($urandom_range(99) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	// Random traffic in four phases. Each phase raises the limit, so the table keeps filling
	// across the whole run instead of in the first few dozen requests, and each phase uses a
	// different mix of sender gaps and receiver stalls.
	task automatic test_random_traffic();
		set_table_limit(7'd24);
		run_traffic(170, 0, 0, 45);
		set_table_limit(7'd40);
		set_first_auto_key(random_word());
		run_traffic(170, 48, 0, 45);
		set_table_limit(7'd64);
		set_first_auto_key(64'hFFFF_FFFF_FFFF_FFF0);
		run_traffic(170, 0, 48, 45);
		set_table_limit(7'd127);
		set_first_auto_key(random_word());
		run_traffic(170, 17, 17, 45);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_insert_and_find();
		test_auto_key_wrap();
		test_table_limit();
		test_random_traffic();
		wait_for_results();
		// Give the block time to show any extra result before the verdict.
		repeat (10) @(posedge clk);
		$display("Sent %0d inserts and %0d finds; %0d entries stored at the end.",
			inserts_sent, finds_sent, table_count);
		$display("Outcomes seen: %0d ok, %0d full, %0d duplicate, %0d not found.",
			outcome_tally[OUT_OK], outcome_tally[OUT_FULL], outcome_tally[OUT_DUP],
			outcome_tally[OUT_NOT_FOUND]);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/skti_pkg.sv
rtl/skti_regs.sv
rtl/skti_ctrl.sv
rtl/skti_dp.sv
rtl/sorted_key_table_insert_find.sv
rtl/skti_checker.sv
test/testbench.sv
